@@ design/mccd_pkg.sv @@
// shared constants, types and helpers for the minimum-coin change block
// no dependencies; imported by the sequencer, compare unit and top level
package mccd_pkg;

  localparam int AMOUNT_LIMIT = 4095;
  localparam int NUM_DENOMS   = 10;
  localparam int NUM_ROWS     = NUM_DENOMS - 1;
  localparam int ROW_LEN      = AMOUNT_LIMIT + 1;
  localparam int TABLE_DEPTH  = NUM_ROWS * ROW_LEN;
  localparam int MAX_RESULTS  = 12;

  localparam int VAL_W   = 12;
  localparam int COUNT_W = 12;
  localparam int COIN_W  = 11;
  localparam int ROW_W   = $clog2(NUM_DENOMS);
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int N_W     = $clog2(MAX_RESULTS + 1);

  // request to and answer from the shared add/compare unit
  typedef struct packed {
    logic [COUNT_W-1:0] drop;
    logic [COUNT_W-1:0] take;
    logic               take_ok;
  } cmp_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] best;
    logic               better;
  } cmp_rsp_t;

  // table write and read requests
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [COUNT_W-1:0] wdata;
  } tbl_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } tbl_rd_t;

  function automatic logic [COIN_W-1:0] denom(input logic [ROW_W-1:0] idx);
    logic [COIN_W-1:0] d;
    case (idx)
      4'd0:    d = COIN_W'(1);
      4'd1:    d = COIN_W'(2);
      4'd2:    d = COIN_W'(5);
      4'd3:    d = COIN_W'(10);
      4'd4:    d = COIN_W'(20);
      4'd5:    d = COIN_W'(50);
      4'd6:    d = COIN_W'(100);
      4'd7:    d = COIN_W'(200);
      4'd8:    d = COIN_W'(500);
      4'd9:    d = COIN_W'(2000);
      default: d = COIN_W'(1);
    endcase
    return d;
  endfunction

  // rows 1..NUM_ROWS are stored; row 0 (ones only) is implicit
  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [ROW_W-1:0] row,
                                                 input logic [VAL_W-1:0] v);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ROW_LEN) * ADDR_W'(row - ROW_W'(1));
    return base + ADDR_W'(v);
  endfunction

endpackage

@@ design/min_coin_change_dp.sv @@
// Minimum-coin change block. Each input beat carries an amount (saturated to
// 4095); the block builds a table of minimum coin counts for the denominations
// 2..2000 against every sub-amount, then walks it back from 2000 downwards and
// sends one coin per output beat, the final one with out_last_coin set. A zero
// amount gives no output beats. One amount is handled at a time and in_stall
// stays high until its last coin has been taken. The fill runs at one table
// entry per cycle through the dual-read table memory and the single add/compare
// unit. Each step of the walk reads the table, then compares; a taken coin is
// held on the output while out_stall is high, and ones left need no compare.
// No clearing pass after reset: every entry whose value is used is written first
// for the same amount.
// depends on mccd_pkg, mccd_ram, mccd_cmp_unit, mccd_seq
module min_coin_change_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mccd_pkg::VAL_W-1:0]  in_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mccd_pkg::COIN_W-1:0] out_coin_value,
  output logic                        out_last_coin
);

  import mccd_pkg::*;

  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;
  logic [COUNT_W-1:0] tbl_rdata_a;
  logic [COUNT_W-1:0] tbl_rdata_b;
  cmp_req_t           cmp_req;
  cmp_rsp_t           cmp_rsp;

  mccd_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coin_value (out_coin_value),
    .out_last_coin  (out_last_coin),
    .tbl_wr         (tbl_wr),
    .tbl_rd         (tbl_rd),
    .tbl_rdata_a    (tbl_rdata_a),
    .tbl_rdata_b    (tbl_rdata_b),
    .cmp_req        (cmp_req),
    .cmp_rsp        (cmp_rsp)
  );

  mccd_cmp_unit u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  mccd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_count_table (
    .clk     (clk),
    .we      (tbl_wr.we),
    .waddr   (tbl_wr.waddr),
    .wdata   (tbl_wr.wdata),
    .raddr_a (tbl_rd.raddr_a),
    .rdata_a (tbl_rdata_a),
    .raddr_b (tbl_rd.raddr_b),
    .rdata_b (tbl_rdata_b)
  );

endmodule

@@ design/mccd_ram.sv @@
// generic single-write, dual-read memory with registered read data
// no dependencies
module mccd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ design/mccd_cmp_unit.sv @@
// shared add/compare unit: one more coin against dropping the denomination
// depends on mccd_pkg
module mccd_cmp_unit (
  input  mccd_pkg::cmp_req_t req,
  output mccd_pkg::cmp_rsp_t rsp
);

  import mccd_pkg::*;

  logic [COUNT_W:0] take_sum;

  always_comb begin
    take_sum   = {1'b0, req.take} + (COUNT_W + 1)'(1);
    rsp.better = req.take_ok && (take_sum < {1'b0, req.drop});
    rsp.best   = rsp.better ? take_sum[COUNT_W-1:0] : req.drop;
  end

endmodule

@@ design/mccd_seq.sv @@
// sequencer: fills the count table row by row, then walks it back and emits coins
// depends on mccd_pkg; drives the table memory and the shared compare unit
module mccd_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mccd_pkg::VAL_W-1:0]   in_amount,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mccd_pkg::COIN_W-1:0]  out_coin_value,
  output logic                         out_last_coin,
  output mccd_pkg::tbl_wr_t            tbl_wr,
  output mccd_pkg::tbl_rd_t            tbl_rd,
  input  logic [mccd_pkg::COUNT_W-1:0] tbl_rdata_a,
  input  logic [mccd_pkg::COUNT_W-1:0] tbl_rdata_b,
  output mccd_pkg::cmp_req_t           cmp_req,
  input  mccd_pkg::cmp_rsp_t           cmp_rsp
);

  import mccd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_FILL     = 5'b00010,
    S_WALK_RD  = 5'b00100,
    S_WALK_CMP = 5'b01000,
    S_OUT      = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  amt_r, amt_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [VAL_W-1:0]  v_r, v_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              st_vld_r, st_vld_nxt;
  logic [VAL_W-1:0]  st_v_r, st_v_nxt;
  logic              st_ok_r, st_ok_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [ROW_W-1:0]  idx_r, idx_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COIN_W-1:0] out_coin_r, out_coin_nxt;
  logic              out_last_r, out_last_nxt;

  logic [COIN_W-1:0] d_sel;
  logic [VAL_W-1:0]  d_val;

  always_comb begin
    state_nxt     = state_r;
    amt_nxt       = amt_r;
    row_nxt       = row_r;
    v_nxt         = v_r;
    iss_done_nxt  = iss_done_r;
    st_vld_nxt    = st_vld_r;
    st_v_nxt      = st_v_r;
    st_ok_nxt     = st_ok_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_coin_nxt  = out_coin_r;
    out_last_nxt  = out_last_r;

    d_sel = denom((state_r == S_FILL) ? row_r : idx_r);
    d_val = VAL_W'(d_sel);

    tbl_wr.we      = 1'b0;
    tbl_wr.waddr   = tbl_addr(row_r, st_v_r);
    tbl_wr.wdata   = cmp_rsp.best;
    tbl_rd.raddr_a = '0;
    tbl_rd.raddr_b = '0;

    cmp_req.drop    = tbl_rdata_a;
    cmp_req.take    = tbl_rdata_b;
    cmp_req.take_ok = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          amt_nxt      = (in_amount > VAL_W'(AMOUNT_LIMIT)) ? VAL_W'(AMOUNT_LIMIT) : in_amount;
          row_nxt      = ROW_W'(1);
          v_nxt        = '0;
          iss_done_nxt = 1'b0;
          st_vld_nxt   = 1'b0;
          state_nxt    = S_FILL;
        end
      end

      S_FILL: begin
        // issue side: reads for sub-amount v_r
        if (!iss_done_r) begin
          tbl_rd.raddr_a = (row_r == ROW_W'(1)) ? '0 : tbl_addr(row_r - ROW_W'(1), v_r);
          tbl_rd.raddr_b = (v_r >= d_val) ? tbl_addr(row_r, v_r - d_val)
                                          : tbl_addr(row_r, '0);
          st_vld_nxt = 1'b1;
          st_v_nxt   = v_r;
          st_ok_nxt  = (v_r >= d_val);
          if (v_r == amt_r) begin
            iss_done_nxt = 1'b1;
          end else begin
            v_nxt = v_r + VAL_W'(1);
          end
        end else begin
          st_vld_nxt = 1'b0;
        end
        // compute side: entry written in the cycle after its reads, so v-2 is always visible
        if (st_vld_r) begin
          cmp_req.drop    = (row_r == ROW_W'(1)) ? COUNT_W'(st_v_r) : tbl_rdata_a;
          cmp_req.take_ok = st_ok_r;
          tbl_wr.we       = 1'b1;
          if (st_v_r == amt_r) begin
            if (row_r == ROW_W'(NUM_ROWS)) begin
              rem_nxt   = amt_r;
              idx_nxt   = ROW_W'(NUM_ROWS);
              n_nxt     = '0;
              state_nxt = S_WALK_RD;
            end else begin
              row_nxt      = row_r + ROW_W'(1);
              v_nxt        = '0;
              iss_done_nxt = 1'b0;
            end
          end
        end
      end

      S_WALK_RD: begin
        if (rem_r == '0 || n_r == N_W'(MAX_RESULTS)) begin
          state_nxt = S_IDLE;
        end else if (idx_r == '0) begin
          // only ones left
          out_coin_nxt  = COIN_W'(1);
          out_last_nxt  = (rem_r == VAL_W'(1)) || (n_r == N_W'(MAX_RESULTS - 1));
          rem_nxt       = rem_r - VAL_W'(1);
          n_nxt         = n_r + N_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          tbl_rd.raddr_a = (idx_r == ROW_W'(1)) ? '0 : tbl_addr(idx_r - ROW_W'(1), rem_r);
          tbl_rd.raddr_b = (rem_r >= d_val) ? tbl_addr(idx_r, rem_r - d_val)
                                            : tbl_addr(idx_r, '0);
          state_nxt = S_WALK_CMP;
        end
      end

      S_WALK_CMP: begin
        cmp_req.drop    = (idx_r == ROW_W'(1)) ? COUNT_W'(rem_r) : tbl_rdata_a;
        cmp_req.take_ok = (rem_r >= d_val);
        if (cmp_rsp.better) begin
          // anything left over yields at least one more coin unless the MAX_RESULTS cap is reached
          out_coin_nxt  = d_sel;
          out_last_nxt  = (rem_r == d_val) || (n_r == N_W'(MAX_RESULTS - 1));
          rem_nxt       = rem_r - d_val;
          n_nxt         = n_r + N_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          idx_nxt   = idx_r - ROW_W'(1);
          state_nxt = S_WALK_RD;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_WALK_RD;
        end
      end

      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_done_r  <= 1'b0;
      st_vld_r    <= 1'b0;
      rem_r       <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_done_r  <= iss_done_nxt;
      st_vld_r    <= st_vld_nxt;
      rem_r       <= rem_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amt_r      <= amt_nxt;
    row_r      <= row_nxt;
    v_r        <= v_nxt;
    st_v_r     <= st_v_nxt;
    st_ok_r    <= st_ok_nxt;
    out_coin_r <= out_coin_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_coin_value = out_coin_r;
  assign out_last_coin  = out_last_r;

endmodule

@@ design/mccd_checker.sv @@
// port-level checks for the minimum-coin change block, bound to the top level
// depends on mccd_pkg for field widths
module mccd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [mccd_pkg::VAL_W-1:0]  in_amount,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mccd_pkg::COIN_W-1:0] out_coin_value,
  input logic                        out_last_coin
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coin_value) && $stable(out_last_coin))
    else $error("stalled result beat changed");

  // no input is taken while a coin is on offer
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while a coin is pending");

  // an accepted amount keeps the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after taking an amount");

  // a coin taken without the last flag means more are coming
  a_more_coins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_coin |=> in_stall)
    else $error("block went idle before the last coin");

  // only real denominations appear
  a_coin_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coin_value == 11'd1 || out_coin_value == 11'd2 ||
                   out_coin_value == 11'd5 || out_coin_value == 11'd10 ||
                   out_coin_value == 11'd20 || out_coin_value == 11'd50 ||
                   out_coin_value == 11'd100 || out_coin_value == 11'd200 ||
                   out_coin_value == 11'd500 || out_coin_value == 11'd2000))
    else $error("coin value is not a denomination");

  logic unused_amount;
  assign unused_amount = ^in_amount;

endmodule

bind min_coin_change_dp mccd_checker u_mccd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_amount      (in_amount),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coin_value (out_coin_value),
  .out_last_coin  (out_last_coin)
);

@@ tb/tb.sv @@
// self-checking bench for min_coin_change_dp: predicts the coin sequence for every amount
// with its own count table and checks each output beat in order
// depends on mccd_pkg and the min_coin_change_dp design files
typedef struct packed {
  logic [mccd_pkg::COIN_W-1:0] value;
  logic                        is_last;
} coin_t;

class coin_scoreboard;
  logic [mccd_pkg::COUNT_W-1:0] counts [1:mccd_pkg::NUM_ROWS][0:mccd_pkg::AMOUNT_LIMIT];
  coin_t outstanding[$];
  int    faults;
  int    amounts_seen;
  int    coins_seen;
  int    largest;

  function int unsigned face_value(int unsigned idx);
    case (idx)
      0: return 1;
      1: return 2;
      2: return 5;
      3: return 10;
      4: return 20;
      5: return 50;
      6: return 100;
      7: return 200;
      8: return 500;
      default: return 2000;
    endcase
  endfunction

  // row 0 is ones only, so its count is the sub-amount itself
  function int unsigned min_count(int unsigned row, int unsigned v);
    if (row == 0) return v;
    return counts[row][v];
  endfunction

  function void note_amount(logic [mccd_pkg::VAL_W-1:0] amt);
    int unsigned a, row, v, best, take, rem, idx;
    int unsigned coins[$];
    coin_t c;
    a = amt;
    if (a > mccd_pkg::AMOUNT_LIMIT) a = mccd_pkg::AMOUNT_LIMIT;
    amounts_seen++;
    if (int'(a) > largest) largest = int'(a);
    for (row = 1; row <= mccd_pkg::NUM_ROWS; row++) begin
      counts[row][0] = '0;
      for (v = 1; v <= a; v++) begin
        best = min_count(row - 1, v);
        if (v >= face_value(row)) begin
          take = 1 + min_count(row, v - face_value(row));
          if (take < best) best = take;
        end
        counts[row][v] = mccd_pkg::COUNT_W'(best);
      end
    end
    // walk back from the largest coin, taking one only when strictly better
    rem = a;
    idx = mccd_pkg::NUM_DENOMS - 1;
    while (rem != 0 && idx > 0 && coins.size() < mccd_pkg::MAX_RESULTS) begin
      if (rem >= face_value(idx) &&
          1 + min_count(idx, rem - face_value(idx)) < min_count(idx - 1, rem)) begin
        coins = {coins, face_value(idx)};
        rem -= face_value(idx);
      end else begin
        idx--;
      end
    end
    while (rem != 0 && coins.size() < mccd_pkg::MAX_RESULTS) begin
      coins = {coins, 32'd1};
      rem--;
    end
    foreach (coins[k]) begin
      c.value   = mccd_pkg::COIN_W'(coins[k]);
      c.is_last = (k == coins.size() - 1);
      outstanding = {outstanding, c};
    end
  endfunction

  function void check_coin(logic [mccd_pkg::COIN_W-1:0] value, logic is_last);
    coin_t want;
    coins_seen++;
    if (outstanding.size() == 0) begin
      faults++;
      $display("%0t: unexpected coin beat, expected none, got value %0d last %0b",
               $time, value, is_last);
      return;
    end
    want = outstanding.pop_front();
    if (value !== want.value) begin
      faults++;
      $display("%0t: coin value expected %0d, got %0d", $time, want.value, value);
    end
    if (is_last !== want.is_last) begin
      faults++;
      $display("%0t: last_coin expected %0b, got %0b", $time, want.is_last, is_last);
    end
  endfunction

  function int pending();
    return outstanding.size();
  endfunction
endclass

module tb;
  localparam int          HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int          DRAIN_CYCLES = 100;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [mccd_pkg::VAL_W-1:0]  in_amount = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [mccd_pkg::COIN_W-1:0] out_coin_value;
  logic                        out_last_coin;

  bit          quiet;
  bit          long_hold;
  int unsigned cycle_count = 0;
  coin_scoreboard change_sb = new;

  // zero, one of every coin, a twelve-coin amount and the saturation edge
  int unsigned corner_amounts [22] = '{0, 1, 2, 3, 4, 6, 7, 8, 9, 13, 25, 40, 99, 388,
                                       1999, 2047, 2048, 2888, 3999, 4095, 0, 5};

  min_coin_change_dp i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coin_value (out_coin_value),
    .out_last_coin  (out_last_coin)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) change_sb.note_amount(in_amount);
    if (rst_n && out_valid && !out_stall) change_sb.check_coin(out_coin_value, out_last_coin);
  end

  function int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 7));
  endfunction

  // mostly small amounts to keep the fill short, a few across the full range
  function int unsigned pick_amount();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(0, 127);
    if (sel < 94) return $urandom_range(128, 1023);
    return $urandom_range(0, mccd_pkg::AMOUNT_LIMIT);
  endfunction

  task automatic send_amount(input int unsigned amt, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_amount <= mccd_pkg::VAL_W'(amt);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // result side: a fresh stall per beat, with one long hold when asked
  initial begin : coin_sink
    int g;
    forever begin
      g = draw_gap();
      if (long_hold) begin
        g = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_amounts[k]) send_amount(corner_amounts[k], draw_gap());

    repeat (30) send_amount(pick_amount(), draw_gap());

    // back-to-back beats on both sides
    quiet = 1'b1;
    repeat (20) send_amount(pick_amount(), 0);
    quiet = 1'b0;

    // sink holds off while small amounts keep arriving, so in_stall backs up
    long_hold = 1'b1;
    repeat (6) send_amount($urandom_range(1, 20), 0);

    repeat (22) send_amount(pick_amount(), draw_gap());
    in_valid <= 1'b0;

    while (change_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d amounts up to %0d, %0d coin beats checked",
             change_sb.amounts_seen, change_sb.largest, change_sb.coins_seen);
    $display("with random gaps, a stall-free stretch and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (change_sb.faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
